// ===== src/dccfb_pkg.sv =====
package dccfb_pkg;

  // Largest payload a write may carry, in bytes.
  localparam int unsigned MAX_DATA_BYTES = 8;

  localparam logic       REQ_WRITE      = 1'b0;
  localparam logic       REQ_READ       = 1'b1;

  localparam logic [7:0]  HDR_ADDR8      = 8'h80;
  localparam logic [7:0]  HDR_ADDR16     = 8'h88;
  localparam logic [15:0] ADDR8_MAX      = 16'h00FF;
  localparam logic [7:0]  READ_BYTE_MAX  = 8'd127;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  localparam logic [2:0]  WT_SINGLE_RESP = 3'd0;
  localparam logic [2:0]  WT_LAST_WITH_ID = 3'd3;

  localparam logic [3:0]  LEN_NONE       = 4'd0;
  localparam logic [3:0]  LEN_ONE        = 4'd1;
  localparam logic [3:0]  LEN_SEVEN      = 4'd7;
  localparam logic [3:0]  LEN_LIMIT      = 4'(MAX_DATA_BYTES);
  localparam logic [3:0]  LEN_FULL       = 4'd8;

  // Classified request, as handed from the front to the back.
  typedef struct packed {
    logic        reject;
    logic [7:0]  header;
    logic        has_id;
    logic [7:0]  dev_id;
    logic        addr16;
    logic [15:0] addr;
    logic [3:0]  len;
    logic [63:0] data;   // first payload byte sits in bits 63:56
  } desc_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_HEADER,
    BK_DEVID,
    BK_ADDR_HI,
    BK_ADDR_LO,
    BK_DATA,
    BK_CRC_LO,
    BK_CRC_HI,
    BK_REJECT
  } back_state_e;

  // CRC-16/ARC over one byte, reflected.
  function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/dccfb_front.sv =====
module dccfb_front
  import dccfb_pkg::*;
(
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  device_id_i,
  input  logic [15:0] reg_address_i,
  input  logic [63:0] write_data_i,
  input  logic [3:0]  data_length_i,
  input  logic [2:0]  write_type_i,
  input  logic [7:0]  return_count_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output desc_t       q_desc_o
);

  logic [7:0]  read_byte;
  logic [3:0]  len;
  logic [2:0]  wtype;
  logic [63:0] raw_data;
  logic [2:0]  pad_bytes;
  logic        addr16;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    read_byte = return_count_i - 8'd1;
    addr16    = reg_address_i > ADDR8_MAX;
    q_desc_o  = '0;

    if (req_type_i == REQ_READ) begin
      len             = LEN_ONE;
      wtype           = WT_SINGLE_RESP;
      raw_data        = {56'd0, read_byte};
      q_desc_o.reject = read_byte > READ_BYTE_MAX;
    end else begin
      len             = data_length_i;
      wtype           = write_type_i;
      raw_data        = write_data_i;
      q_desc_o.reject = (data_length_i == LEN_NONE) || (data_length_i == LEN_SEVEN) ||
                        (data_length_i > LEN_LIMIT);
    end

    // Move the first payload byte to the top of the word.
    pad_bytes = 3'(LEN_FULL - len);

    q_desc_o.header = (addr16 ? HDR_ADDR16 : HDR_ADDR8) | {1'b0, wtype, 4'b0000} |
                      {4'b0000, len};
    q_desc_o.has_id = wtype <= WT_LAST_WITH_ID;
    q_desc_o.dev_id = device_id_i;
    q_desc_o.addr16 = addr16;
    q_desc_o.addr   = reg_address_i;
    q_desc_o.len    = len;
    q_desc_o.data   = raw_data << {pad_bytes, 3'b000};
  end

endmodule

// ===== src/dccfb_fifo.sv =====
module dccfb_fifo
  import dccfb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t desc_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output desc_t desc_o
);

  desc_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign desc_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

// ===== src/dccfb_back.sv =====
module dccfb_back
  import dccfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  desc_t       q_desc_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        last_byte_o,
  output logic        rejected_o
);

  back_state_e state_q, state_d;
  desc_t       cur_q;
  logic [63:0] data_q;
  logic [2:0]  cnt_q;
  logic [15:0] crc_q;
  logic        adv;
  logic        data_done;

  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        emit_rej;
  logic        crc_upd;

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic        out_rej_q;

  // Output slot is free when empty or being taken.
  assign adv       = !out_valid_q || !out_stall_i;
  assign data_done = ({1'b0, cnt_q} + 4'd1) == cur_q.len;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) state_d = q_desc_i.reject ? BK_REJECT : BK_HEADER;
      end
      BK_HEADER: begin
        if (adv) state_d = cur_q.has_id ? BK_DEVID : (cur_q.addr16 ? BK_ADDR_HI : BK_ADDR_LO);
      end
      BK_DEVID: begin
        if (adv) state_d = cur_q.addr16 ? BK_ADDR_HI : BK_ADDR_LO;
      end
      BK_ADDR_HI: begin
        if (adv) state_d = BK_ADDR_LO;
      end
      BK_ADDR_LO: begin
        if (adv) state_d = BK_DATA;
      end
      BK_DATA: begin
        if (adv && data_done) state_d = BK_CRC_LO;
      end
      BK_CRC_LO: begin
        if (adv) state_d = BK_CRC_HI;
      end
      BK_CRC_HI: begin
        if (adv) state_d = BK_IDLE;
      end
      BK_REJECT: begin
        if (adv) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    emit_byte = 8'h00;
    emit_last = 1'b0;
    emit_rej  = 1'b0;
    crc_upd   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        q_pop_o = !q_empty_i;
      end
      BK_HEADER: begin
        emit      = 1'b1;
        emit_byte = cur_q.header;
        crc_upd   = 1'b1;
      end
      BK_DEVID: begin
        emit      = 1'b1;
        emit_byte = cur_q.dev_id;
        crc_upd   = 1'b1;
      end
      BK_ADDR_HI: begin
        emit      = 1'b1;
        emit_byte = cur_q.addr[15:8];
        crc_upd   = 1'b1;
      end
      BK_ADDR_LO: begin
        emit      = 1'b1;
        emit_byte = cur_q.addr[7:0];
        crc_upd   = 1'b1;
      end
      BK_DATA: begin
        emit      = 1'b1;
        emit_byte = data_q[63:56];
        crc_upd   = 1'b1;
      end
      BK_CRC_LO: begin
        emit      = 1'b1;
        emit_byte = crc_q[7:0];
      end
      BK_CRC_HI: begin
        emit      = 1'b1;
        emit_byte = crc_q[15:8];
        emit_last = 1'b1;
      end
      BK_REJECT: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        emit_rej  = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (adv) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q  <= q_desc_i;
      data_q <= q_desc_i.data;
      cnt_q  <= 3'd0;
      crc_q  <= 16'h0000;
    end else if (adv && emit) begin
      if (crc_upd) begin
        crc_q <= crc_arc_byte(crc_q, emit_byte);
      end
      if (state_q == BK_DATA) begin
        data_q <= data_q << 8;
        cnt_q  <= cnt_q + 3'd1;
      end
    end
    if (adv) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
      out_rej_q  <= emit_rej;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign last_byte_o  = out_last_q;
  assign rejected_o   = out_rej_q;

endmodule

// ===== src/daisy_chain_command_frame_builder.sv =====
// Daisy-chain command frame builder.
//
// Input channel: one request per transfer (in_valid_i high, in_stall_o low).
// A request is a register write or a read request; it is checked and
// classified on entry and parked in a two-entry queue.
// Output channel: the frame leaves one byte per transfer: header, optional
// device ID, one or two address bytes, payload bytes, then CRC-16/ARC low
// byte first. last_byte_o marks the final byte. A bad request gives a single
// transfer with rejected_o and last_byte_o high and frame_byte_o zero.
// A frame is 5 to 14 bytes long. The byte sequencer in the back end pulls
// one request from the queue only while idle and then emits one byte per
// cycle while the receiver does not stall; it takes the next request only
// after the last byte of the current frame has gone to the output register.
// Receiver stall: the output register holds its byte; the sequencer waits;
// the queue keeps taking requests until both entries are filled, then
// in_stall_o rises.
// Reset: queue emptied, sequencer idle, no output valid.
module daisy_chain_command_frame_builder
  import dccfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  device_id_i,
  input  logic [15:0] reg_address_i,
  input  logic [63:0] write_data_i,
  input  logic [3:0]  data_length_i,
  input  logic [2:0]  write_type_i,
  input  logic [7:0]  return_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        last_byte_o,
  output logic        rejected_o
);

  desc_t push_desc;
  desc_t head_desc;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_empty;

  // Classify the request and push it on transfer.
  dccfb_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .device_id_i    (device_id_i),
    .reg_address_i  (reg_address_i),
    .write_data_i   (write_data_i),
    .data_length_i  (data_length_i),
    .write_type_i   (write_type_i),
    .return_count_i (return_count_i),
    .q_full_i       (q_full),
    .q_push_o       (push),
    .q_desc_o       (push_desc)
  );

  // Decouple intake from byte emission.
  dccfb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .desc_o  (head_desc)
  );

  // Sequence the frame bytes and run the CRC.
  dccfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_desc_i     (head_desc),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o),
    .rejected_o   (rejected_o)
  );

endmodule

// ===== src/dccfb_checker.sv =====
module dccfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] frame_byte_o,
  input logic       last_byte_o,
  input logic       rejected_o
);

  // Hold a stalled byte.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_byte_o) &&
    $stable(last_byte_o) && $stable(rejected_o))
    else $error("stalled output changed");

  // A reject is a single zero byte that closes its frame.
  a_reject_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> last_byte_o && (frame_byte_o == 8'h00))
    else $error("malformed reject");

  // Inside a frame, bytes follow without gaps.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_byte_o |=> out_valid_o && !rejected_o)
    else $error("gap inside frame");

endmodule

bind daisy_chain_command_frame_builder dccfb_checker u_dccfb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .frame_byte_o (frame_byte_o),
  .last_byte_o  (last_byte_o),
  .rejected_o   (rejected_o)
);
